// ===== hdl/hdd_pkg.sv =====
// ============================================================================
// hdd_pkg
// Shared types and constants of the four-channel Hadamard delay diffuser:
// channel words, register indexes, input modes and sequencer control.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hdd_pkg;

    // Fixed field widths of the channel words
    localparam int SAMPLE_W = 24;
    localparam int MODE_W   = 2;
    localparam int SEL_W    = 4;
    localparam int LEN_IN_W = 13;
    localparam int CHANNELS = 4;
    localparam int MIX_W    = SAMPLE_W + 2;

    // Configuration register indexes
    localparam logic CFG_STAGE_COUNT = 1'b0;
    localparam logic CFG_MIX_SHIFT   = 1'b1;

    // Input word modes
    localparam logic [MODE_W-1:0] MODE_PROCESS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    // Last phase of the six-phase stage walk
    localparam logic [2:0] PHASE_LAST = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [SEL_W-1:0]           line_select;
        logic [LEN_IN_W-1:0]        line_length_in;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_ch0;
        logic signed [SAMPLE_W-1:0] out_ch1;
        logic signed [SAMPLE_W-1:0] out_ch2;
        logic signed [SAMPLE_W-1:0] out_ch3;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic       idle;
        logic       load;
        logic       clearing;
        logic       run;
        logic [2:0] phase;
        logic       out_load;
    } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/hadamard_delay_diffuser_top.sv =====
// Sample word: the stage walk over each stage in use is set by one read port each
// on the line table and delay store; the output word is loaded after the last
// stage, and the next word is taken once it is loaded. Length load: clamped
// length, zero position. Clear word: zeroes the store, one entry a cycle.
// Reset: lengths 1, positions 0, then a sweep zeroes all NUM_LINES*LINE_DEPTH
// store entries (65536 for the defaults) before the first word is taken.
// ============================================================================
// hadamard_delay_diffuser_top
// Mono-in, four-channel-out multistage Hadamard delay diffuser. All delay
// lines share one store; lengths and write positions share a line table.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hadamard_delay_diffuser_top #(
    parameter int MAX_STAGES = 4,
    parameter int LINE_DEPTH = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_stall,
    input  wire hdd_pkg::in_word_t in_data,
    output      logic              out_valid,
    input  wire logic              out_stall,
    output      hdd_pkg::out_word_t out_data,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [2:0]        cfg_data
);

    localparam int NUM_LINES = MAX_STAGES * hdd_pkg::CHANNELS;
    localparam int TOTAL     = NUM_LINES * LINE_DEPTH;
    localparam int ADDR_W    = $clog2(TOTAL);
    localparam int LINE_W    = $clog2(NUM_LINES);
    localparam int STG_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int POS_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W     = $clog2(LINE_DEPTH + 1);
    localparam int CMP_W     = (LEN_W > hdd_pkg::LEN_IN_W) ? LEN_W : hdd_pkg::LEN_IN_W;
    localparam int SW        = hdd_pkg::SAMPLE_W;

    hdd_pkg::seq_ctrl_t ctrl;
    logic [STG_W-1:0]   stage;
    logic [ADDR_W-1:0]  clr_addr;
    logic               in_fire;
    logic               out_free;

    logic [2:0]         stage_count_reg;
    logic [1:0]         mix_shift_reg;
    hdd_pkg::in_word_t  item_reg;
    hdd_pkg::out_word_t out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [NUM_LINES-1:0] len_valid_reg;
    logic [NUM_LINES-1:0] pos_valid_reg;

    logic [hdd_pkg::CHANNELS-1:0][POS_W-1:0] pos_reg;
    logic [hdd_pkg::CHANNELS-1:0][SW-1:0]    tap_reg;
    logic [hdd_pkg::CHANNELS-1:0][SW-1:0]    mix_reg;
    logic [hdd_pkg::CHANNELS-1:0][SW-1:0]    mix_res;

    logic                    lt_we;
    logic [LINE_W-1:0]       lt_waddr;
    logic [LEN_W+POS_W-1:0]  lt_wdata;
    logic                    lt_re;
    logic [LINE_W-1:0]       lt_raddr;
    logic [LEN_W+POS_W-1:0]  lt_rdata;

    logic                    dly_we;
    logic [ADDR_W-1:0]       dly_waddr;
    logic [SW-1:0]           dly_wdata;
    logic                    dly_re;
    logic [ADDR_W-1:0]       dly_raddr;
    logic [SW-1:0]           dly_rdata;

    logic                    upd_phase;
    logic                    wr_phase;
    logic [2:0]              upd_off;
    logic [2:0]              wr_off;
    logic [1:0]              upd_ch;
    logic [1:0]              wr_ch;
    logic [LINE_W-1:0]       upd_line;
    logic [LINE_W-1:0]       wr_line;
    logic [LEN_W-1:0]        len_eff;
    logic [POS_W-1:0]        pos_eff;
    logic [LEN_W-1:0]        pos_inc;
    logic [POS_W-1:0]        pos_next;
    logic [CMP_W-1:0]        len_wide;
    logic [LEN_W-1:0]        len_clamp;
    logic                    sel_ok;

    // Base of a line in the store plus the position within it
    function automatic logic [ADDR_W-1:0] line_addr(
        input logic [LINE_W-1:0] ln,
        input logic [POS_W-1:0]  ps
    );
        line_addr = ADDR_W'(ln) * ADDR_W'(LINE_DEPTH) + ADDR_W'(ps);
    endfunction

    // Handshakes
    assign in_fire   = in_valid && ctrl.idle;
    assign in_stall  = !ctrl.idle;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    hdd_seq #(
        .MAX_STAGES(MAX_STAGES),
        .LINE_DEPTH(LINE_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_mode    (in_data.mode),
        .stage_count(stage_count_reg),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .stage      (stage),
        .clr_addr   (clr_addr)
    );

    hdd_mix u_mix (
        .taps (tap_reg),
        .shift(mix_shift_reg),
        .mixed(mix_res)
    );

    // Phase decode: table data arrives in phases 1..4, store data in 2..5
    assign upd_phase = ctrl.run && ctrl.phase >= 3'd1 && ctrl.phase <= 3'd4;
    assign wr_phase  = ctrl.run && ctrl.phase >= 3'd2;
    assign upd_off   = ctrl.phase - 3'd1;
    assign wr_off    = ctrl.phase - 3'd2;
    assign upd_ch    = upd_off[1:0];
    assign wr_ch     = wr_off[1:0];
    assign upd_line  = LINE_W'({stage, upd_ch});
    assign wr_line   = LINE_W'({stage, wr_ch});

    // Line table entry, with reset values where never written
    assign len_eff  = len_valid_reg[upd_line] ? lt_rdata[LEN_W+POS_W-1:POS_W] : LEN_W'(1);
    assign pos_eff  = pos_valid_reg[upd_line] ? lt_rdata[POS_W-1:0] : '0;
    assign pos_inc  = LEN_W'(pos_eff) + LEN_W'(1);
    assign pos_next = (pos_inc >= len_eff) ? '0 : POS_W'(pos_inc);

    // Clamp a loaded length to one..LINE_DEPTH; drop loads past the lines present
    assign len_wide  = CMP_W'(item_reg.line_length_in);
    assign len_clamp = (len_wide == '0) ? LEN_W'(1) :
                       (len_wide > CMP_W'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH) :
                       LEN_W'(len_wide);
    assign sel_ok    = {2'b00, item_reg.line_select} < 6'(NUM_LINES);

    // Line table port control
    always_comb
    begin
        lt_re    = ctrl.run && ctrl.phase <= 3'd3;
        lt_raddr = LINE_W'({stage, ctrl.phase[1:0]});
        lt_we    = 1'b0;
        lt_waddr = upd_line;
        lt_wdata = {len_eff, pos_next};
        if (ctrl.load)
        begin
            lt_we    = sel_ok;
            lt_waddr = LINE_W'(item_reg.line_select);
            lt_wdata = {len_clamp, {POS_W{1'b0}}};
        end
        else if (upd_phase)
        begin
            lt_we = 1'b1;
        end
    end

    // Delay store port control
    always_comb
    begin
        dly_re    = upd_phase;
        dly_raddr = line_addr(upd_line, pos_eff);
        dly_we    = 1'b0;
        dly_waddr = line_addr(wr_line, pos_reg[wr_ch]);
        dly_wdata = mix_reg[wr_ch];
        if (ctrl.clearing)
        begin
            dly_we    = 1'b1;
            dly_waddr = clr_addr;
            dly_wdata = '0;
        end
        else if (wr_phase)
        begin
            dly_we = 1'b1;
            if (stage == '0)
            begin
                dly_wdata = (wr_ch == 2'd0) ? item_reg.sample_in
                                            : tap_reg[2'(wr_ch - 2'd1)];
            end
        end
    end

    hdd_ram #(
        .WIDTH(LEN_W + POS_W),
        .DEPTH(NUM_LINES)
    ) u_line_table (
        .clk  (clk),
        .we   (lt_we),
        .waddr(lt_waddr),
        .wdata(lt_wdata),
        .re   (lt_re),
        .raddr(lt_raddr),
        .rdata(lt_rdata)
    );

    hdd_ram #(
        .WIDTH(SW),
        .DEPTH(TOTAL)
    ) u_delay_store (
        .clk  (clk),
        .we   (dly_we),
        .waddr(dly_waddr),
        .wdata(dly_wdata),
        .re   (dly_re),
        .raddr(dly_raddr),
        .rdata(dly_rdata)
    );

    // Output word valid flag
    assign out_valid_next = ctrl.out_load || (out_valid_reg && out_stall);

    // Control registers: configuration, valid bits, output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= 3'd1;
            mix_shift_reg   <= 2'd0;
            len_valid_reg   <= '0;
            pos_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hdd_pkg::CFG_STAGE_COUNT: stage_count_reg <= cfg_data;
                    hdd_pkg::CFG_MIX_SHIFT:   mix_shift_reg   <= cfg_data[1:0];
                    default:                  stage_count_reg <= stage_count_reg;
                endcase
            end
            if (ctrl.clearing)
            begin
                pos_valid_reg <= '0;
            end
            else if (lt_we)
            begin
                len_valid_reg[lt_waddr] <= 1'b1;
                pos_valid_reg[lt_waddr] <= 1'b1;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: held item, positions, taps, mix and output word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (upd_phase)
        begin
            pos_reg[upd_ch] <= pos_eff;
        end
        if (wr_phase)
        begin
            tap_reg[wr_ch] <= dly_rdata;
        end
        if (ctrl.run && ctrl.phase == 3'd0 && stage != '0)
        begin
            mix_reg <= mix_res;
        end
        if (ctrl.out_load)
        begin
            out_reg.out_ch0 <= mix_res[0];
            out_reg.out_ch1 <= mix_res[1];
            out_reg.out_ch2 <= mix_res[2];
            out_reg.out_ch3 <= mix_res[3];
        end
    end

`ifndef SYNTHESIS
    // Store never sees a read and a write of one entry in the same cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (dly_re && dly_we) |-> (dly_raddr != dly_waddr))
        else $error("delay store read and write collide");

    // Each stage write lands on the entry read in the cycle before
    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_phase |-> (dly_we && dly_waddr == $past(dly_raddr) && $past(dly_re)))
        else $error("delay store write address does not follow its read");

    // A waiting output word is never overwritten
    a_no_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !ctrl.out_load)
        else $error("output word overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== hdl/hdd_ram.sv =====
// ============================================================================
// hdd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read sees the old contents when the same entry is written
// in the same cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hdd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hdd_mix.sv =====
// ============================================================================
// hdd_mix
// Sign-flipped four-point Hadamard mix of four taps, each sum shifted
// right arithmetically and saturated to a signed 24-bit sample.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hdd_mix (
    input  wire logic [hdd_pkg::CHANNELS-1:0][hdd_pkg::SAMPLE_W-1:0] taps,
    input  wire logic [1:0]                                          shift,
    output      logic [hdd_pkg::CHANNELS-1:0][hdd_pkg::SAMPLE_W-1:0] mixed
);

    localparam int W = hdd_pkg::MIX_W;

    logic signed [W-1:0] ta;
    logic signed [W-1:0] tb;
    logic signed [W-1:0] tc;
    logic signed [W-1:0] td;
    logic signed [W-1:0] sum_ac;
    logic signed [W-1:0] sum_bd;
    logic signed [W-1:0] sum_ad;
    logic signed [W-1:0] sum_bc;
    logic signed [W-1:0] sum_ab;
    logic signed [W-1:0] sum_cd;

    // Floor shift, then clamp to the 24-bit range
    function automatic logic [hdd_pkg::SAMPLE_W-1:0] shift_sat(
        input logic signed [W-1:0] v,
        input logic [1:0]          sh
    );
        logic signed [W-1:0] r;
        r = v >>> sh;
        if (r[W-1:W-3] == 3'b000 || r[W-1:W-3] == 3'b111)
        begin
            shift_sat = r[hdd_pkg::SAMPLE_W-1:0];
        end
        else if (r[W-1])
        begin
            shift_sat = {1'b1, {(hdd_pkg::SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            shift_sat = {1'b0, {(hdd_pkg::SAMPLE_W-1){1'b1}}};
        end
    endfunction

    // Widen the taps
    assign ta = {{2{taps[0][hdd_pkg::SAMPLE_W-1]}}, taps[0]};
    assign tb = {{2{taps[1][hdd_pkg::SAMPLE_W-1]}}, taps[1]};
    assign tc = {{2{taps[2][hdd_pkg::SAMPLE_W-1]}}, taps[2]};
    assign td = {{2{taps[3][hdd_pkg::SAMPLE_W-1]}}, taps[3]};

    // Pair sums; the a+c and b+d sums are shared by outputs 0 and 1
    assign sum_ac = ta + tc;
    assign sum_bd = tb + td;
    assign sum_ad = ta + td;
    assign sum_bc = tb + tc;
    assign sum_ab = ta + tb;
    assign sum_cd = tc + td;

    assign mixed[0] = shift_sat(sum_ac - sum_bd, shift);
    assign mixed[1] = shift_sat(sum_ac + sum_bd, shift);
    assign mixed[2] = shift_sat(sum_ad - sum_bc, shift);
    assign mixed[3] = shift_sat(sum_ab - sum_cd, shift);

endmodule

`default_nettype wire

// ===== hdl/hdd_seq.sv =====
// ============================================================================
// hdd_seq
// Sequencer of the diffuser: clearing sweep, length loads, and the
// six-phase walk over each stage in use, followed by the output load.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hdd_seq #(
    parameter int MAX_STAGES = 4,
    parameter int LINE_DEPTH = 4096,
    localparam int STG_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
    localparam int TOTAL     = MAX_STAGES * hdd_pkg::CHANNELS * LINE_DEPTH,
    localparam int ADDR_W    = $clog2(TOTAL)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_fire,
    input  wire logic [hdd_pkg::MODE_W-1:0]  in_mode,
    input  wire logic [2:0]                  stage_count,
    input  wire logic                        out_free,
    output      hdd_pkg::seq_ctrl_t          ctrl,
    output      logic [STG_W-1:0]            stage,
    output      logic [ADDR_W-1:0]           clr_addr
);

    hdd_pkg::seq_state_t state_reg;
    hdd_pkg::seq_state_t state_next;
    logic [2:0]          phase_reg;
    logic [2:0]          phase_next;
    logic [STG_W-1:0]    stage_reg;
    logic [STG_W-1:0]    stage_next;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [ADDR_W-1:0]   clr_cnt_next;
    logic [3:0]          sc_wide;
    logic [3:0]          stages_used;
    logic [STG_W-1:0]    last_stage;
    logic                stage_done;
    logic                clear_done;

    // Number of stages in use: zero counts as one, clamp at the maximum
    assign sc_wide     = {1'b0, stage_count};
    assign stages_used = (sc_wide == 4'd0) ? 4'd1 :
                         (sc_wide > 4'(MAX_STAGES)) ? 4'(MAX_STAGES) : sc_wide;
    assign last_stage  = STG_W'(stages_used - 4'd1);
    assign stage_done  = (phase_reg == hdd_pkg::PHASE_LAST);
    assign clear_done  = (clr_cnt_reg == ADDR_W'(TOTAL - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hdd_pkg::ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = hdd_pkg::ST_IDLE;
                end
            end
            hdd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_mode)
                        hdd_pkg::MODE_PROCESS: state_next = hdd_pkg::ST_RUN;
                        hdd_pkg::MODE_LOAD:    state_next = hdd_pkg::ST_LOAD;
                        hdd_pkg::MODE_CLEAR:   state_next = hdd_pkg::ST_CLEAR;
                        default:               state_next = hdd_pkg::ST_IDLE;
                    endcase
                end
            end
            hdd_pkg::ST_LOAD:
            begin
                state_next = hdd_pkg::ST_IDLE;
            end
            hdd_pkg::ST_RUN:
            begin
                if (stage_done && stage_reg == last_stage)
                begin
                    state_next = hdd_pkg::ST_FINISH;
                end
            end
            hdd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = hdd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hdd_pkg::ST_IDLE;
            end
        endcase
    end

    // Advance phase, stage and sweep counters
    always_comb
    begin
        phase_next   = 3'd0;
        stage_next   = '0;
        clr_cnt_next = '0;
        if (state_reg == hdd_pkg::ST_RUN)
        begin
            phase_next = stage_done ? 3'd0 : phase_reg + 3'd1;
            stage_next = stage_done ? stage_reg + STG_W'(1) : stage_reg;
        end
        if (state_reg == hdd_pkg::ST_CLEAR && !clear_done)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end
    end

    // Outputs
    always_comb
    begin
        ctrl.idle     = (state_reg == hdd_pkg::ST_IDLE);
        ctrl.load     = (state_reg == hdd_pkg::ST_LOAD);
        ctrl.clearing = (state_reg == hdd_pkg::ST_CLEAR);
        ctrl.run      = (state_reg == hdd_pkg::ST_RUN);
        ctrl.phase    = phase_reg;
        ctrl.out_load = (state_reg == hdd_pkg::ST_FINISH) && out_free;
        stage         = stage_reg;
        clr_addr      = clr_cnt_reg;
    end

    // Hold state; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hdd_pkg::ST_CLEAR;
            phase_reg   <= 3'd0;
            stage_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

endmodule

`default_nettype wire
